// ===== design/ocu_pkg.sv =====
package ocu_pkg;

    // CORDIC depth; the arctangent table covers up to ATAN_DEPTH steps
    localparam int TRIG_ITERATIONS = 16;
    localparam int ATAN_DEPTH      = 24;
    localparam int ATAN_IDX_W      = $clog2(ATAN_DEPTH);
    localparam int ITER_W          = $clog2(TRIG_ITERATIONS + 1);

    localparam int ANGLE_W   = 16;
    localparam int Q15_W     = 16;
    localparam int STICK_W   = 16;
    localparam int POS_W     = 32;
    localparam int CORDIC_W  = 32;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_YAW_SPEED      = 3'd0,
        CFG_PITCH_SPEED    = 3'd1,
        CFG_PITCH_LIMIT    = 3'd2,
        CFG_LERP_FRACTION  = 3'd3,
        CFG_ORBIT_DISTANCE = 3'd4
    } cfg_index_t;

    localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 32'sd652032874;

    // sin/cos pair in Q1.15
    typedef struct packed {
        logic signed [Q15_W-1:0] sin_q;
        logic signed [Q15_W-1:0] cos_q;
    } trig_t;

    // atan(2^-i) in units of 2^30 per quarter turn
    function automatic logic signed [CORDIC_W-1:0] atan_step(
        input logic [ATAN_IDX_W-1:0] idx
    );
        logic signed [CORDIC_W-1:0] v;
        case (idx)
            5'd0:    v = 32'sh20000000;
            5'd1:    v = 32'sh12E4051E;
            5'd2:    v = 32'sh09FB385B;
            5'd3:    v = 32'sh051111D4;
            5'd4:    v = 32'sh028B0D43;
            5'd5:    v = 32'sh0145D7E1;
            5'd6:    v = 32'sh00A2F61E;
            5'd7:    v = 32'sh00517C55;
            5'd8:    v = 32'sh0028BE53;
            5'd9:    v = 32'sh00145F2F;
            5'd10:   v = 32'sh000A2F98;
            5'd11:   v = 32'sh000517CC;
            5'd12:   v = 32'sh00028BE6;
            5'd13:   v = 32'sh000145F3;
            5'd14:   v = 32'sh0000A2FA;
            5'd15:   v = 32'sh0000517D;
            5'd16:   v = 32'sh000028BE;
            5'd17:   v = 32'sh0000145F;
            5'd18:   v = 32'sh00000A30;
            5'd19:   v = 32'sh00000518;
            5'd20:   v = 32'sh0000028C;
            5'd21:   v = 32'sh00000146;
            5'd22:   v = 32'sh000000A3;
            5'd23:   v = 32'sh00000051;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== design/ocu_cordic.sv =====
module ocu_cordic (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [ocu_pkg::ANGLE_W-1:0]   angle,
    output logic                          done,
    output ocu_pkg::trig_t                result
);
    import ocu_pkg::*;

    logic                        busy_reg;
    logic                        done_reg;
    logic [ITER_W-1:0]           iter_reg;
    logic signed [CORDIC_W-1:0]  x_reg, y_reg, z_reg;
    logic                        flip_reg;
    trig_t                       result_reg;

    logic signed [16:0]          za, zf;
    logic                        flip_next;
    logic signed [CORDIC_W-1:0]  z_start;
    logic signed [CORDIC_W-1:0]  dx, dy, at;
    logic signed [CORDIC_W-1:0]  x_fin, y_fin;

    function automatic logic signed [Q15_W-1:0] to_q15(input logic signed [CORDIC_W-1:0] v);
        logic signed [CORDIC_W:0] t;
        logic signed [17:0]       r;
        t = (CORDIC_W+1)'(v) + 33'sd16384;
        r = 18'(t >>> 15);
        if (r > 18'sd32767) begin
            return 16'sh7FFF;
        end else if (r < -18'sd32768) begin
            return 16'sh8000;
        end else begin
            return r[15:0];
        end
    endfunction

    // fold the angle into [-90, 90] degrees
    always_comb begin
        za = 17'($signed(angle));
        zf = za;
        flip_next = 1'b0;
        if (za > 17'sd16384) begin
            zf = za - 17'sd32768;
            flip_next = 1'b1;
        end else if (za < -17'sd16384) begin
            zf = za + 17'sd32768;
            flip_next = 1'b1;
        end
        z_start = CORDIC_W'(zf) <<< 16;
    end

    assign dx = y_reg >>> iter_reg;
    assign dy = x_reg >>> iter_reg;
    assign at = atan_step(ATAN_IDX_W'(iter_reg));
    assign x_fin = flip_reg ? -x_reg : x_reg;
    assign y_fin = flip_reg ? -y_reg : y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end else begin
            done_reg <= !start && busy_reg && (iter_reg == ITER_W'(TRIG_ITERATIONS));
            if (start) begin
                busy_reg <= 1'b1;
                iter_reg <= '0;
                x_reg    <= CORDIC_X0;
                y_reg    <= '0;
                z_reg    <= z_start;
                flip_reg <= flip_next;
            end else if (busy_reg) begin
                if (iter_reg == ITER_W'(TRIG_ITERATIONS)) begin
                    busy_reg         <= 1'b0;
                    result_reg.sin_q <= to_q15(y_fin);
                    result_reg.cos_q <= to_q15(x_fin);
                end else begin
                    if (!z_reg[CORDIC_W-1]) begin
                        x_reg <= x_reg - dx;
                        y_reg <= y_reg + dy;
                        z_reg <= z_reg - at;
                    end else begin
                        x_reg <= x_reg + dx;
                        y_reg <= y_reg - dy;
                        z_reg <= z_reg + at;
                    end
                    iter_reg <= iter_reg + 1'b1;
                end
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== design/orbit_camera_update.sv =====
// Orbit camera update. Each input word (right stick and followed target) moves
// the goal yaw/pitch, eases the shown angles toward them and returns one word
// with the camera position and the target used. From acceptance to m_valid a
// word passes through two back-to-back runs of the single CORDIC rotator, one
// iteration per cycle, and 14 sequencer steps that share one registered
// multiplier. s_ready is high only while the sequencer is idle; a finished
// word waits in the output register, so the next word can be taken before
// it is read. Config writes are taken every cycle and should be made between
// words.
module orbit_camera_update (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [ocu_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [ocu_pkg::CFG_DATA_W-1:0]        cfg_data,

    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [ocu_pkg::STICK_W-1:0]    s_stick_x,
    input  logic signed [ocu_pkg::STICK_W-1:0]    s_stick_y,
    input  logic                                  s_target_present,
    input  logic signed [ocu_pkg::POS_W-1:0]      s_target_x,
    input  logic signed [ocu_pkg::POS_W-1:0]      s_target_y,
    input  logic signed [ocu_pkg::POS_W-1:0]      s_target_z,

    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [ocu_pkg::POS_W-1:0]      m_camera_x,
    output logic signed [ocu_pkg::POS_W-1:0]      m_camera_y,
    output logic signed [ocu_pkg::POS_W-1:0]      m_camera_z,
    output logic signed [ocu_pkg::POS_W-1:0]      m_look_x,
    output logic signed [ocu_pkg::POS_W-1:0]      m_look_y,
    output logic signed [ocu_pkg::POS_W-1:0]      m_look_z
);
    import ocu_pkg::*;

    localparam logic [9:0]               STICK_FULL  = 10'd1000;
    // ceil(2^34 / 1000): exact floor division for products below 2^24
    localparam logic signed [32:0]       RECIP_1000  = 33'sd17179870;
    localparam logic signed [17:0]       PITCH_TOP   = -18'sd2086;
    localparam logic signed [ANGLE_W-1:0] RESET_PITCH = 16'sd5215;

    typedef enum logic [4:0] {
        S_IDLE, S_YSTEP, S_YDIV, S_PSTEP, S_PDIV, S_GPITCH, S_YLERP, S_PLERP,
        S_TRIG_P, S_WAIT_P, S_TRIG_Y, S_WAIT_Y,
        S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_DONE
    } state_t;

    state_t                      state_reg;

    logic [13:0]                 yaw_speed_reg;
    logic [13:0]                 pitch_speed_reg;
    logic [14:0]                 pitch_limit_reg;
    logic [16:0]                 lerp_fraction_reg;
    logic [23:0]                 orbit_distance_reg;

    logic [ANGLE_W-1:0]          goal_yaw_reg, shown_yaw_reg;
    logic signed [ANGLE_W-1:0]   goal_pitch_reg, shown_pitch_reg;

    logic signed [STICK_W-1:0]   sx_reg, sy_reg;
    logic signed [POS_W-1:0]     tx_reg, ty_reg, tz_reg;
    logic signed [Q15_W-1:0]     sinp_reg, cosp_reg, siny_reg, cosy_reg;
    logic signed [POS_W-1:0]     camx_reg, camy_reg, camz_reg;
    logic signed [57:0]          prod_reg;

    logic                        m_valid_reg;
    logic signed [POS_W-1:0]     m_camera_x_reg, m_camera_y_reg, m_camera_z_reg;
    logic signed [POS_W-1:0]     m_look_x_reg, m_look_y_reg, m_look_z_reg;
    logic                        out_load;

    logic signed [32:0]          mul_a;
    logic signed [24:0]          mul_b;

    logic [13:0]                 step_mag;
    logic [ANGLE_W-1:0]          goal_yaw_next, shown_yaw_next;
    logic signed [ANGLE_W-1:0]   goal_pitch_next, shown_pitch_next;
    logic signed [17:0]          pstep, pitch_raw, pitch_low;
    logic signed [ANGLE_W-1:0]   dyaw;
    logic signed [16:0]          dpitch;
    logic [16:0]                 dyaw_mag, dpitch_mag;
    logic [16:0]                 lerp_mag;
    logic signed [18:0]          lerp_s, pitch_sum;

    logic                        trig_start;
    logic [ANGLE_W-1:0]          trig_angle;
    logic                        trig_done;
    trig_t                       trig_res;

    function automatic logic [9:0] stick_mag(input logic signed [STICK_W-1:0] s);
        logic signed [STICK_W:0] se;
        logic [STICK_W:0]        a;
        se = (STICK_W+1)'(s);
        a  = s[STICK_W-1] ? -se : se;
        if (a > (STICK_W+1)'(STICK_FULL)) begin
            return STICK_FULL;
        end else begin
            return a[9:0];
        end
    endfunction

    function automatic logic signed [POS_W-1:0] sat_add(
        input logic signed [42:0]      off,
        input logic signed [POS_W-1:0] t
    );
        logic signed [43:0] sum;
        sum = 44'(off) + 44'(t);
        if (sum[43:31] == {13{sum[43]}}) begin
            return sum[31:0];
        end else begin
            return sum[43] ? 32'sh80000000 : 32'sh7FFFFFFF;
        end
    endfunction

    ocu_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (trig_start),
        .angle   (trig_angle),
        .done    (trig_done),
        .result  (trig_res)
    );

    assign trig_start = (state_reg == S_TRIG_P) || (state_reg == S_TRIG_Y);
    assign trig_angle = (state_reg == S_TRIG_P) ? shown_pitch_reg : shown_yaw_reg;
    assign out_load   = (state_reg == S_DONE) && (!m_valid_reg || m_ready);

    // shared multiplier operand select; product lands in prod_reg next cycle
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_YSTEP: begin
                mul_a = 33'(yaw_speed_reg);
                mul_b = 25'(stick_mag(sx_reg));
            end
            S_PSTEP: begin
                mul_a = 33'(pitch_speed_reg);
                mul_b = 25'(stick_mag(sy_reg));
            end
            S_YDIV, S_PDIV: begin
                mul_a = RECIP_1000;
                mul_b = 25'(prod_reg[23:0]);
            end
            S_GPITCH: begin
                mul_a = 33'(lerp_fraction_reg);
                mul_b = 25'(dyaw_mag);
            end
            S_YLERP: begin
                mul_a = 33'(lerp_fraction_reg);
                mul_b = 25'(dpitch_mag);
            end
            S_M1: begin
                mul_a = 33'(cosp_reg);
                mul_b = 25'(siny_reg);
            end
            S_M3: begin
                mul_a = 33'(cosp_reg);
                mul_b = 25'(cosy_reg);
            end
            S_M2, S_M4: begin
                mul_a = 33'($signed(prod_reg[31:0]));
                mul_b = 25'(orbit_distance_reg);
            end
            S_M5: begin
                mul_a = 33'(sinp_reg);
                mul_b = 25'(orbit_distance_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // angle updates from the registered product
    always_comb begin
        step_mag = prod_reg[47:34];

        goal_yaw_next = sx_reg[STICK_W-1] ? goal_yaw_reg - 16'(step_mag)
                                          : goal_yaw_reg + 16'(step_mag);

        pstep     = $signed(18'(step_mag));
        pstep     = sy_reg[STICK_W-1] ? -pstep : pstep;
        pitch_raw = 18'(goal_pitch_reg) - pstep;
        pitch_low = -$signed(18'(pitch_limit_reg));
        // low bound first, then the top cap wins when they cross
        if (pitch_raw < pitch_low) begin
            pitch_raw = pitch_low;
        end
        if (pitch_raw > PITCH_TOP) begin
            pitch_raw = PITCH_TOP;
        end
        goal_pitch_next = pitch_raw[15:0];

        dyaw     = $signed(goal_yaw_reg - shown_yaw_reg);
        dyaw_mag = dyaw[ANGLE_W-1] ? 17'(-17'(dyaw)) : 17'(17'(dyaw));
        dpitch   = 17'(goal_pitch_reg) - 17'(shown_pitch_reg);
        dpitch_mag = dpitch[16] ? 17'(-dpitch) : 17'(dpitch);

        lerp_mag = prod_reg[32:16];
        shown_yaw_next = dyaw[ANGLE_W-1] ? shown_yaw_reg - lerp_mag[15:0]
                                         : shown_yaw_reg + lerp_mag[15:0];

        lerp_s    = $signed(19'(lerp_mag));
        pitch_sum = 19'(shown_pitch_reg) + (dpitch[16] ? -lerp_s : lerp_s);
        if (pitch_sum > 19'sd32767) begin
            shown_pitch_next = 16'sh7FFF;
        end else if (pitch_sum < -19'sd32768) begin
            shown_pitch_next = 16'sh8000;
        end else begin
            shown_pitch_next = pitch_sum[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;

        if (!aresetn) begin
            state_reg          <= S_IDLE;
            yaw_speed_reg      <= 14'd300;
            pitch_speed_reg    <= 14'd300;
            pitch_limit_reg    <= 15'd11000;
            lerp_fraction_reg  <= 17'd13107;
            orbit_distance_reg <= 24'd655360;
            goal_yaw_reg       <= '0;
            shown_yaw_reg      <= '0;
            goal_pitch_reg     <= RESET_PITCH;
            shown_pitch_reg    <= RESET_PITCH;
            m_valid_reg        <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_YAW_SPEED:      yaw_speed_reg      <= cfg_data[13:0];
                    CFG_PITCH_SPEED:    pitch_speed_reg    <= cfg_data[13:0];
                    CFG_PITCH_LIMIT:    pitch_limit_reg    <= cfg_data[14:0];
                    CFG_LERP_FRACTION:  lerp_fraction_reg  <= cfg_data[16:0];
                    CFG_ORBIT_DISTANCE: orbit_distance_reg <= cfg_data[23:0];
                    default: ;
                endcase
            end

            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        sx_reg    <= s_stick_x;
                        sy_reg    <= s_stick_y;
                        tx_reg    <= s_target_present ? s_target_x : '0;
                        ty_reg    <= s_target_present ? s_target_y : '0;
                        tz_reg    <= s_target_present ? s_target_z : '0;
                        state_reg <= S_YSTEP;
                    end
                end
                S_YSTEP:  state_reg <= S_YDIV;
                S_YDIV:   state_reg <= S_PSTEP;
                S_PSTEP: begin
                    goal_yaw_reg <= goal_yaw_next;
                    state_reg    <= S_PDIV;
                end
                S_PDIV:   state_reg <= S_GPITCH;
                S_GPITCH: begin
                    goal_pitch_reg <= goal_pitch_next;
                    state_reg      <= S_YLERP;
                end
                S_YLERP: begin
                    shown_yaw_reg <= shown_yaw_next;
                    state_reg     <= S_PLERP;
                end
                S_PLERP: begin
                    shown_pitch_reg <= shown_pitch_next;
                    state_reg       <= S_TRIG_P;
                end
                S_TRIG_P: state_reg <= S_WAIT_P;
                S_WAIT_P: begin
                    if (trig_done) begin
                        sinp_reg  <= trig_res.sin_q;
                        cosp_reg  <= trig_res.cos_q;
                        state_reg <= S_TRIG_Y;
                    end
                end
                S_TRIG_Y: state_reg <= S_WAIT_Y;
                S_WAIT_Y: begin
                    if (trig_done) begin
                        siny_reg  <= trig_res.sin_q;
                        cosy_reg  <= trig_res.cos_q;
                        state_reg <= S_M1;
                    end
                end
                S_M1: state_reg <= S_M2;
                S_M2: state_reg <= S_M3;
                S_M3: begin
                    camx_reg  <= sat_add(43'($signed(prod_reg[57:30])), tx_reg);
                    state_reg <= S_M4;
                end
                S_M4: state_reg <= S_M5;
                S_M5: begin
                    camz_reg  <= sat_add(43'($signed(prod_reg[57:30])), tz_reg);
                    state_reg <= S_M6;
                end
                S_M6: begin
                    camy_reg  <= sat_add($signed(prod_reg[57:15]), ty_reg);
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    // wait for the output word to be free
                    if (out_load) begin
                        m_camera_x_reg <= camx_reg;
                        m_camera_y_reg <= camy_reg;
                        m_camera_z_reg <= camz_reg;
                        m_look_x_reg   <= tx_reg;
                        m_look_y_reg   <= ty_reg;
                        m_look_z_reg   <= tz_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign cfg_ready  = 1'b1;
    assign s_ready    = (state_reg == S_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_camera_x = m_camera_x_reg;
    assign m_camera_y = m_camera_y_reg;
    assign m_camera_z = m_camera_z_reg;
    assign m_look_x   = m_look_x_reg;
    assign m_look_y   = m_look_y_reg;
    assign m_look_z   = m_look_z_reg;

endmodule

// ===== design/ocu_checker.sv =====
module ocu_checker (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    input  logic                                  s_ready,
    input  logic                                  m_valid,
    input  logic                                  m_ready,
    input  logic signed [ocu_pkg::POS_W-1:0]      m_camera_x,
    input  logic signed [ocu_pkg::POS_W-1:0]      m_camera_y,
    input  logic signed [ocu_pkg::POS_W-1:0]      m_camera_z,
    input  logic signed [ocu_pkg::POS_W-1:0]      m_look_x,
    input  logic signed [ocu_pkg::POS_W-1:0]      m_look_y,
    input  logic signed [ocu_pkg::POS_W-1:0]      m_look_z
);
    import ocu_pkg::*;

    // reset leaves no word pending and the input side open
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("ocu: bad state after reset");

    // one word at a time: input closes right after a word is taken
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ocu: input taken while busy");

    // a new result only comes out of a busy sequencer
    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("ocu: result without a word in work");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_camera_x) && $stable(m_camera_y)
            && $stable(m_camera_z) && $stable(m_look_x) && $stable(m_look_y)
            && $stable(m_look_z))
        else $error("ocu: stalled output word changed");

endmodule

bind orbit_camera_update ocu_checker u_ocu_checker (.*);
